// ----- design/pee_pkg.sv -----
// pee_pkg: widths, symbol codes and status codes of the postfix evaluator
// no dependencies; imported by the interfaces and all design modules
package pee_pkg;

    localparam int DATA_W   = 32;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 3;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd4;

endpackage

// ----- design/pee_cmd_if.sv -----
// pee_cmd_if: symbol channel, valid/ready with symbol and end mark
// depends on pee_pkg
interface pee_cmd_if
    import pee_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ----- design/pee_res_if.sv -----
// pee_res_if: result channel, valid/ready with answer and status
// depends on pee_pkg
interface pee_res_if
    import pee_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] answer;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output answer, output status, input ready);
    modport sink   (input valid, input answer, input status, output ready);
endinterface

// ----- design/pee_stack.sv -----
// pee_stack: operand store below the top of stack, one write and one read port
// synchronous read into an output register loaded when re is high; depends on pee_pkg
module pee_stack
    import pee_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pee_div.sv -----
// pee_div: signed 32-bit divider truncating toward zero, one quotient bit per cycle
// restoring division on magnitudes; depends on pee_pkg
module pee_div
    import pee_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int CW = $clog2(DATA_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(DATA_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ----- design/postfix_expression_evaluator.sv -----
// postfix_expression_evaluator: stack machine evaluating postfix expressions
// depends on pee_pkg, pee_cmd_if, pee_res_if, pee_stack, pee_div
//
// cmd carries one ASCII symbol per word with an end-of-expression mark; a digit
// pushes its value, + - * / pop right then left and push the 32-bit result
// res carries one word per expression: answer (top of stack) and a status
// code (ok, underflow, overflow, divide by zero, unsupported symbol)
// the top of stack sits in a register, the rest in a synchronous memory
// a digit or a rejected symbol is done in S_IDLE; + - * pass through S_RD (memory
// read of the left operand, then the alu); / goes on from S_RD to S_DIV and waits for
// the one-bit-per-cycle divider; the end-marked word then passes S_FIN to load res
// after the first error the remaining symbols are skipped up to the end mark
// reset empties the stack and clears the error; memory contents are not reset
// and need no clearing pass
// res holds its word until taken; cmd keeps being accepted meanwhile, and only
// an end-marked word waits for the res register to free up
module postfix_expression_evaluator
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    pee_cmd_if.sink   cmd,
    pee_res_if.source res
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [DATA_W-1:0]   tos_reg, tos_next;
    logic [SYM_W-1:0]    op_reg, op_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   answer_reg, answer_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic              accept;
    logic              is_digit;
    logic              is_op;
    logic              launch;
    logic              fin_go;
    logic [SPW-1:0]    sp_m1;
    logic [SPW-1:0]    sp_m2;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;
    logic [DATA_W-1:0] alu_res;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    assign accept   = cmd.valid && cmd.ready;
    assign is_digit = (cmd.symbol >= CH_ZERO) && (cmd.symbol <= CH_NINE);
    assign is_op    = (cmd.symbol == CH_PLUS) || (cmd.symbol == CH_MINUS) ||
                      (cmd.symbol == CH_STAR) || (cmd.symbol == CH_SLASH);
    assign sp_m1    = sp_reg - SPW'(1);
    assign sp_m2    = sp_reg - SPW'(2);
    assign fin_go   = !out_valid_reg || res.ready;

    always_comb
    begin
        case (op_reg)
            CH_PLUS:  alu_res = mem_rdata + tos_reg;
            CH_MINUS: alu_res = mem_rdata - tos_reg;
            CH_STAR:  alu_res = mem_rdata * tos_reg;
            default:  alu_res = mem_rdata;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        tos_next       = tos_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !res.ready;
        answer_next    = answer_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        launch         = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = cmd.symbol;
                    last_next = cmd.last_symbol;
                    if (err_reg == ST_OK)
                    begin
                        if (is_digit)
                        begin
                            if (sp_reg == SP_FULL)
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we   = (sp_reg != '0);
                                tos_next = DATA_W'(cmd.symbol - CH_ZERO);
                                sp_next  = sp_reg + SPW'(1);
                            end
                        end
                        else if (!is_op)
                        begin
                            err_next = ST_UNSUPPORTED;
                        end
                        else if (sp_reg < SP_TWO)
                        begin
                            err_next = ST_UNDERFLOW;
                        end
                        else if ((cmd.symbol == CH_SLASH) && (tos_reg == '0))
                        begin
                            err_next = ST_DIVZERO;
                        end
                        else
                        begin
                            launch = 1'b1;
                            mem_re = 1'b1;
                        end
                    end
                    if (launch)
                    begin
                        state_next = S_RD;
                    end
                    else if (cmd.last_symbol)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_RD:
            begin
                if (op_reg == CH_SLASH)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    tos_next   = alu_res;
                    sp_next    = sp_m1;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tos_next   = div_q;
                    sp_next    = sp_m1;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg != ST_OK)
                    begin
                        answer_next = '0;
                        status_next = err_reg;
                    end
                    else if (sp_reg == '0)
                    begin
                        answer_next = '0;
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        answer_next = tos_reg;
                        status_next = ST_OK;
                    end
                    sp_next    = '0;
                    err_next   = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg    <= tos_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
        answer_reg <= answer_next;
        status_reg <= status_next;
    end

    pee_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (sp_m1[AW-1:0]),
        .wdata (tos_reg),
        .re    (mem_re),
        .raddr (sp_m2[AW-1:0]),
        .rdata (mem_rdata)
    );

    pee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mem_rdata),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cmd.ready  = (state_reg == S_IDLE);
    assign res.valid  = out_valid_reg;
    assign res.answer = $signed(answer_reg);
    assign res.status = status_reg;

    // stack pointer never passes the stack size
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SP_FULL)
        else $error("stack pointer out of range");

    // with an error pending the stack is frozen until the expression ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && state_reg != S_FIN) |=> $stable(sp_reg))
        else $error("stack moved after error");

    // a new result word appears only out of the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result loaded outside final state");

    // finishing an expression leaves an empty stack and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && fin_go) |=> (sp_reg == '0 && err_reg == ST_OK))
        else $error("stack not cleared after expression");

    // the divider reports only while its quotient is awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider done outside divide state");

endmodule

// ----- tb/tb_postfix_expression_evaluator.sv -----
// tb_postfix_expression_evaluator: self-checking bench for the postfix stack evaluator
// drives symbol words, predicts answer and status with a shadow stack, checks every result
// depends on pee_pkg, pee_cmd_if, pee_res_if and postfix_expression_evaluator
module tb_postfix_expression_evaluator
    import pee_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 64;
    localparam int TARGET_WORDS = 1050;
    localparam int IDLE_PCT     = 35;
    localparam int QUIET_START  = 1800;
    localparam int QUIET_END    = 2600;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_LEN     = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [SYM_W-1:0] SYM_NUL      = 8'h00;
    localparam logic [SYM_W-1:0] SYM_ALL_ONES = 8'hFF;
    localparam logic [SYM_W-1:0] SYM_PERCENT  = 8'h25;
    localparam logic [SYM_W-1:0] SYM_CARET    = 8'h5E;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             last;
        bit               wait_idle;
    } sym_word_t;

    typedef struct {
        logic signed [DATA_W-1:0] answer;
        logic [STATUS_W-1:0]      status;
    } answer_word_t;

    logic clk;
    logic rst_n;

    pee_cmd_if cmd_bus ();
    pee_res_if res_bus ();

    postfix_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    sym_word_t        symbol_q[$];
    answer_word_t     pending_answers[$];
    logic [SYM_W-1:0] expr_buf[$];

    logic [DATA_W-1:0]   shadow_stack [0:STACK_DEPTH-1];
    int                  shadow_depth = 0;
    logic [STATUS_W-1:0] shadow_error = ST_OK;

    int live_words   = 0;
    int total_words  = 0;
    int words_taken  = 0;
    int mismatches   = 0;
    int tx_cycles    = 0;
    int rx_cycles    = 0;
    int hold_left    = 0;
    int stall_cycles = 0;

    function automatic void evaluate_symbol(input logic [SYM_W-1:0] sym, input logic last);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] mag_l;
        logic [DATA_W-1:0] mag_r;
        answer_word_t      outcome;
        if (shadow_error == ST_OK)
        begin
            if (sym >= CH_ZERO && sym <= CH_NINE)
            begin
                if (shadow_depth >= STACK_DEPTH)
                    shadow_error = ST_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_depth] = DATA_W'(sym - CH_ZERO);
                    shadow_depth++;
                end
            end
            else if (sym != CH_PLUS && sym != CH_MINUS && sym != CH_STAR && sym != CH_SLASH)
                shadow_error = ST_UNSUPPORTED;
            else if (shadow_depth < 2)
                shadow_error = ST_UNDERFLOW;
            else
            begin
                rhs = shadow_stack[shadow_depth-1];
                lhs = shadow_stack[shadow_depth-2];
                if (sym == CH_SLASH && rhs == '0)
                    shadow_error = ST_DIVZERO;
                else
                begin
                    case (sym)
                        CH_PLUS:  lhs = lhs + rhs;
                        CH_MINUS: lhs = lhs - rhs;
                        CH_STAR:  lhs = lhs * rhs;
                        default:
                        begin
                            // magnitudes divide unsigned, sign fixed after: truncates toward zero
                            mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                            mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                            lhs = mag_l / mag_r;
                            if (sym[0] && (shadow_stack[shadow_depth-2][DATA_W-1] ^ rhs[DATA_W-1]))
                                lhs = -lhs;
                        end
                    endcase
                    shadow_depth--;
                    shadow_stack[shadow_depth-1] = lhs;
                end
            end
        end
        if (last)
        begin
            outcome.answer = '0;
            outcome.status = shadow_error;
            if (shadow_error == ST_OK)
            begin
                if (shadow_depth == 0)
                    outcome.status = ST_UNDERFLOW;
                else
                    outcome.answer = shadow_stack[shadow_depth-1];
            end
            pending_answers.push_back(outcome);
            shadow_depth = 0;
            shadow_error = ST_OK;
        end
    endfunction

    function automatic logic [SYM_W-1:0] digit_sym(input int value);
        return CH_ZERO + SYM_W'(value);
    endfunction

    function automatic logic [SYM_W-1:0] any_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    task automatic add_sym(input logic [SYM_W-1:0] sym);
        expr_buf.push_back(sym);
    endtask

    // well-formed expression, leaves keep entries on the stack
    task automatic build_expr(input int operands, input int keep);
        int depth;
        int left;
        depth = 0;
        left = operands;
        while (left > 0 || depth > keep)
        begin
            if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 0))
            begin
                add_sym(digit_sym($urandom_range(0, 9)));
                depth++;
                left--;
            end
            else
            begin
                add_sym(any_operator());
                depth--;
            end
        end
    endtask

    task automatic add_ignored(output int count);
        count = $urandom_range(0, 3);
        repeat (count) add_sym(SYM_W'($urandom_range(0, 255)));
    endtask

    task automatic flush_expr(input int ignored, input bit pause);
        foreach (expr_buf[i])
            symbol_q.push_back('{sym: expr_buf[i], last: (i == expr_buf.size() - 1),
                                 wait_idle: (pause && i == 0)});
        live_words += expr_buf.size() - ignored;
        expr_buf.delete();
    endtask

    // 2 raised to 31 wraps to the most negative value
    task automatic build_int_min(input bit divide);
        add_sym(digit_sym(2));
        repeat (DATA_W - 2)
        begin
            add_sym(digit_sym(2));
            add_sym(CH_STAR);
        end
        if (divide)
        begin
            add_sym(digit_sym(0));
            add_sym(digit_sym(1));
            add_sym(CH_MINUS);
            add_sym(CH_SLASH);
        end
        else
        begin
            add_sym(digit_sym(1));
            add_sym(CH_MINUS);
        end
    endtask

    task automatic build_overflow();
        repeat (STACK_DEPTH + 1) add_sym(digit_sym($urandom_range(0, 9)));
    endtask

    task automatic build_full_stack();
        repeat (STACK_DEPTH) add_sym(digit_sym($urandom_range(1, 9)));
        repeat (STACK_DEPTH - 1) add_sym(any_operator());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_words
        sym_word_t word;
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.symbol <= '0;
            cmd_bus.last_symbol <= 1'b0;
        end
        else
        begin
            tx_cycles++;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                evaluate_symbol(cmd_bus.symbol, cmd_bus.last_symbol);
                words_taken++;
            end
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (symbol_q.size() != 0
                    && ((tx_cycles >= QUIET_START && tx_cycles < QUIET_END)
                        || $urandom_range(0, 99) >= IDLE_PCT)
                    && !(symbol_q[0].wait_idle && pending_answers.size() != 0))
                begin
                    word = symbol_q.pop_front();
                    cmd_bus.valid <= 1'b1;
                    cmd_bus.symbol <= word.sym;
                    cmd_bus.last_symbol <= word.last;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_answers
        answer_word_t want;
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            rx_cycles++;
            if (rx_cycles == HOLD_AT)
                hold_left = HOLD_LEN;
            if (res_bus.valid && res_bus.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual answer %0d status %0d",
                             $time, res_bus.answer, res_bus.status);
                    mismatches++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (res_bus.answer !== want.answer)
                    begin
                        $display("%0t: answer mismatch, expected %0d, actual %0d",
                                 $time, want.answer, res_bus.answer);
                        mismatches++;
                    end
                    if (res_bus.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, res_bus.status);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= (rx_cycles >= QUIET_START && rx_cycles < QUIET_END)
                                 || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_postfix_expression_evaluator NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int  pick;
        int  ignored;
        int  pos;
        int  operands;
        bit  paused;
        logic [SYM_W-1:0] scratch[$];

        paused = 1'b0;

        // directed corners
        add_sym(CH_ZERO);
        flush_expr(0, 1'b0);
        add_sym(CH_NINE);
        flush_expr(0, 1'b0);
        add_sym(digit_sym(9));
        add_sym(digit_sym(8));
        add_sym(CH_STAR);
        add_sym(digit_sym(3));
        add_sym(CH_PLUS);
        flush_expr(0, 1'b0);
        add_sym(digit_sym(0));
        add_sym(digit_sym(7));
        add_sym(CH_MINUS);
        add_sym(digit_sym(2));
        add_sym(CH_SLASH);
        flush_expr(0, 1'b0);
        add_sym(digit_sym(5));
        add_sym(digit_sym(0));
        add_sym(CH_SLASH);
        flush_expr(0, 1'b0);
        add_sym(CH_PLUS);
        add_sym(digit_sym(5));
        flush_expr(1, 1'b0);
        add_sym(SYM_NUL);
        flush_expr(0, 1'b0);
        add_sym(SYM_ALL_ONES);
        flush_expr(0, 1'b0);
        add_sym(digit_sym(4));
        add_sym(SYM_PERCENT);
        flush_expr(0, 1'b0);
        add_sym(SYM_CARET);
        flush_expr(0, 1'b0);
        add_sym(digit_sym(1));
        add_sym(digit_sym(2));
        flush_expr(0, 1'b0);

        // long corners once up front
        build_overflow();
        add_ignored(ignored);
        flush_expr(ignored + 1, 1'b0);
        build_int_min(1'b1);
        flush_expr(0, 1'b0);
        build_int_min(1'b0);
        flush_expr(0, 1'b0);
        build_full_stack();
        flush_expr(0, 1'b0);

        while (live_words < TARGET_WORDS)
        begin
            pick = $urandom_range(0, 99);
            operands = $urandom_range(1, 8);
            if (pick < 64)
            begin
                build_expr(operands, ($urandom_range(0, 4) == 0) ?
                           $urandom_range(1, operands) : 1);
                flush_expr(0, !paused && live_words >= TARGET_WORDS / 2);
                if (live_words >= TARGET_WORDS / 2)
                    paused = 1'b1;
            end
            else if (pick < 72)
            begin
                build_expr(operands, 1);
                pos = $urandom_range(0, expr_buf.size());
                scratch = expr_buf;
                expr_buf.delete();
                foreach (scratch[i])
                begin
                    if (i == pos)
                        add_sym(SYM_W'($urandom_range(0, 255)));
                    add_sym(scratch[i]);
                end
                if (pos == scratch.size())
                    add_sym(SYM_W'($urandom_range(0, 255)));
                flush_expr(expr_buf.size() - pos - 1, 1'b0);
            end
            else if (pick < 79)
            begin
                build_expr(operands, 1);
                add_sym(any_operator());
                add_ignored(ignored);
                flush_expr(ignored, 1'b0);
            end
            else if (pick < 86)
            begin
                build_expr(operands, 1);
                add_sym(digit_sym(0));
                add_sym(CH_SLASH);
                add_ignored(ignored);
                flush_expr(ignored, 1'b0);
            end
            else if (pick < 93)
            begin
                add_sym(digit_sym(9));
                repeat ($urandom_range(6, 14))
                begin
                    add_sym(digit_sym($urandom_range(7, 9)));
                    add_sym(($urandom_range(0, 3) == 0) ? any_operator() : CH_STAR);
                end
                flush_expr(0, 1'b0);
            end
            else if (pick < 94)
            begin
                build_overflow();
                add_ignored(ignored);
                flush_expr(ignored + 1, 1'b0);
            end
            else if (pick < 95)
            begin
                build_int_min(1'($urandom_range(0, 1)));
                flush_expr(0, 1'b0);
            end
            else if (pick < 96)
            begin
                build_expr($urandom_range(16, STACK_DEPTH), 1);
                flush_expr(0, 1'b0);
            end
            else
            begin
                add_sym(SYM_W'($urandom_range(0, 255)));
                flush_expr(0, 1'b0);
            end
        end
        total_words = symbol_q.size() + words_taken;

        while (words_taken < total_words) @(posedge clk);
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_postfix_expression_evaluator OK");
        else
            $display("tb_postfix_expression_evaluator NOT OK");
        $finish;
    end

endmodule
